/* sv/sop_pkg.sv */
// Shared kind codes, test modes and fixed widths for the shape overlap test.
`timescale 1ns / 1ps

package sop_pkg;

  localparam int KIND_W = 2;
  localparam int SIZE_W = 15;
  localparam int LIM_W  = SIZE_W + 2;   // doubled radius or doubled radius sum
  localparam int SQ_W   = 2 * LIM_W;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECT   = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_RR,   // rectangle vs rectangle
    MODE_RC,   // rectangle vs circle, closed test
    MODE_CC    // circle vs circle, open test
  } mode_t;

endpackage

/* sv/shape_overlap_test_core.sv */
// Pipelined overlap test for a pair of 2D shapes (circle / rectangle / none).
`timescale 1ns / 1ps
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------------------
//  s_*      in   s_tvalid/s_tready  tuser: a_kind, b_kind; tdata: shapes a, b
//  m_*      out  m_tvalid/m_tready  tdata: hit
//
//  Four register stages, one transaction per cycle while m_tready does not stall;
//  m_tvalid is the stage 4 valid bit, so a result is offered once it reaches stage 4.
//  The 17x17 squaring in stage 3 and the sum and compare in stage 4 set the
//  stage depth.
//  rst (synchronous) clears the stage valid bits only.
//  A stall on m_tready holds each occupied stage whose later stages are all full;
//  empty stages keep filling, so s_tready drops only when all four stages hold data.

module shape_overlap_test_core #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_kind[1:0], b_kind[3:2]
  input  logic [2*sop_pkg::KIND_W-1:0] s_tuser,
  // lowest up: a_x, a_y, a_w, a_h, a_r, b_x, b_y, b_w, b_h, b_r, zero fill
  input  logic [((4*COORD_BITS+6*sop_pkg::SIZE_W+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit[0], zero fill
  output logic [7:0] m_tdata
);
  import sop_pkg::*;

  // Field offsets inside s_tdata
  localparam int OFS_AX = 0;
  localparam int OFS_AY = OFS_AX + COORD_BITS;
  localparam int OFS_AW = OFS_AY + COORD_BITS;
  localparam int OFS_AH = OFS_AW + SIZE_W;
  localparam int OFS_AR = OFS_AH + SIZE_W;
  localparam int OFS_BX = OFS_AR + SIZE_W;
  localparam int OFS_BY = OFS_BX + COORD_BITS;
  localparam int OFS_BW = OFS_BY + COORD_BITS;
  localparam int OFS_BH = OFS_BW + SIZE_W;
  localparam int OFS_BR = OFS_BH + SIZE_W;

  // Signed width for doubled coordinates, interval bounds and their differences
  localparam int BASE_W = (COORD_BITS + 1 > SIZE_W + 1) ? COORD_BITS + 1 : SIZE_W + 1;
  localparam int EW     = BASE_W + 3;
  localparam int DW     = EW - 1;   // magnitude of a clamp distance

  // ---------------------------------------------------------------- fields
  logic [KIND_W-1:0]     a_kind, b_kind;
  logic [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
  logic [SIZE_W-1:0]     a_w, a_h, a_r, b_w, b_h, b_r;

  assign a_kind = s_tuser[KIND_W-1:0];
  assign b_kind = s_tuser[2*KIND_W-1:KIND_W];
  assign a_x = s_tdata[OFS_AX +: COORD_BITS];
  assign a_y = s_tdata[OFS_AY +: COORD_BITS];
  assign a_w = s_tdata[OFS_AW +: SIZE_W];
  assign a_h = s_tdata[OFS_AH +: SIZE_W];
  assign a_r = s_tdata[OFS_AR +: SIZE_W];
  assign b_x = s_tdata[OFS_BX +: COORD_BITS];
  assign b_y = s_tdata[OFS_BY +: COORD_BITS];
  assign b_w = s_tdata[OFS_BW +: SIZE_W];
  assign b_h = s_tdata[OFS_BH +: SIZE_W];
  assign b_r = s_tdata[OFS_BR +: SIZE_W];

  // ---------------------------------------------------------------- flow control
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Doubled centers, interval bounds. Rectangle/circle pairs are ordered so
  // that P is the rectangle; circle pairs treat shape a as a zero-size box.
  logic signed [EW-1:0] ax2, ay2, bx2, by2;
  logic signed [EW-1:0] aw_e, ah_e, bw_e, bh_e;
  logic [SIZE_W:0]      r_sum;

  assign ax2 = {{(EW-COORD_BITS-1){a_x[COORD_BITS-1]}}, a_x, 1'b0};
  assign ay2 = {{(EW-COORD_BITS-1){a_y[COORD_BITS-1]}}, a_y, 1'b0};
  assign bx2 = {{(EW-COORD_BITS-1){b_x[COORD_BITS-1]}}, b_x, 1'b0};
  assign by2 = {{(EW-COORD_BITS-1){b_y[COORD_BITS-1]}}, b_y, 1'b0};
  assign aw_e = {{(EW-SIZE_W){1'b0}}, a_w};
  assign ah_e = {{(EW-SIZE_W){1'b0}}, a_h};
  assign bw_e = {{(EW-SIZE_W){1'b0}}, b_w};
  assign bh_e = {{(EW-SIZE_W){1'b0}}, b_h};
  assign r_sum = {1'b0, a_r} + {1'b0, b_r};

  mode_t                s1_mode_next, s1_mode;
  logic signed [EW-1:0] s1_pxlo_next, s1_pxhi_next, s1_pylo_next, s1_pyhi_next;
  logic signed [EW-1:0] s1_qxlo_next, s1_qxhi_next, s1_qylo_next, s1_qyhi_next;
  logic signed [EW-1:0] s1_cx_next, s1_cy_next;
  logic [LIM_W-1:0]     s1_lim_next;
  logic signed [EW-1:0] s1_pxlo, s1_pxhi, s1_pylo, s1_pyhi;
  logic signed [EW-1:0] s1_qxlo, s1_qxhi, s1_qylo, s1_qyhi;
  logic signed [EW-1:0] s1_cx, s1_cy;
  logic [LIM_W-1:0]     s1_lim;

  always_comb begin
    // rectangle b bounds, used by the rectangle pair test
    s1_qxlo_next = bx2 - bw_e;
    s1_qxhi_next = bx2 + bw_e;
    s1_qylo_next = by2 - bh_e;
    s1_qyhi_next = by2 + bh_e;
    // default: P is shape a, circle is shape b
    s1_pxlo_next = ax2 - aw_e;
    s1_pxhi_next = ax2 + aw_e;
    s1_pylo_next = ay2 - ah_e;
    s1_pyhi_next = ay2 + ah_e;
    s1_cx_next   = bx2;
    s1_cy_next   = by2;
    s1_lim_next  = {1'b0, b_r, 1'b0};
    s1_mode_next = MODE_NONE;
    if (a_kind == KIND_RECT && b_kind == KIND_RECT) begin
      s1_mode_next = MODE_RR;
    end else if (a_kind == KIND_RECT && b_kind == KIND_CIRCLE) begin
      s1_mode_next = MODE_RC;
    end else if (a_kind == KIND_CIRCLE && b_kind == KIND_RECT) begin
      s1_mode_next = MODE_RC;
      s1_pxlo_next = bx2 - bw_e;
      s1_pxhi_next = bx2 + bw_e;
      s1_pylo_next = by2 - bh_e;
      s1_pyhi_next = by2 + bh_e;
      s1_cx_next   = ax2;
      s1_cy_next   = ay2;
      s1_lim_next  = {1'b0, a_r, 1'b0};
    end else if (a_kind == KIND_CIRCLE && b_kind == KIND_CIRCLE) begin
      // point box at a's center: clamp distance becomes |a - b|
      s1_mode_next = MODE_CC;
      s1_pxlo_next = ax2;
      s1_pxhi_next = ax2;
      s1_pylo_next = ay2;
      s1_pyhi_next = ay2;
      s1_lim_next  = {r_sum, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode <= s1_mode_next;
      s1_pxlo <= s1_pxlo_next;
      s1_pxhi <= s1_pxhi_next;
      s1_pylo <= s1_pylo_next;
      s1_pyhi <= s1_pyhi_next;
      s1_qxlo <= s1_qxlo_next;
      s1_qxhi <= s1_qxhi_next;
      s1_qylo <= s1_qylo_next;
      s1_qyhi <= s1_qyhi_next;
      s1_cx   <= s1_cx_next;
      s1_cy   <= s1_cy_next;
      s1_lim  <= s1_lim_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Strict interval test, clamp distances, squared limit.
  logic signed [EW-1:0] dxlo, dxhi, dylo, dyhi;
  logic [DW-1:0]        s2_dx_next, s2_dy_next;
  logic                 s2_rr_next;
  mode_t                s2_mode;
  logic                 s2_rr;
  logic [DW-1:0]        s2_dx, s2_dy;
  logic [LIM_W-1:0]     s2_lim;
  logic [SQ_W-1:0]      s2_lim_sq;

  assign dxlo = s1_pxlo - s1_cx;
  assign dxhi = s1_cx - s1_pxhi;
  assign dylo = s1_pylo - s1_cy;
  assign dyhi = s1_cy - s1_pyhi;

  always_comb begin
    if (dxlo > 0)      s2_dx_next = dxlo[DW-1:0];
    else if (dxhi > 0) s2_dx_next = dxhi[DW-1:0];
    else               s2_dx_next = '0;
    if (dylo > 0)      s2_dy_next = dylo[DW-1:0];
    else if (dyhi > 0) s2_dy_next = dyhi[DW-1:0];
    else               s2_dy_next = '0;
    s2_rr_next = (s1_pxlo < s1_qxhi) && (s1_pxhi > s1_qxlo) &&
                 (s1_pylo < s1_qyhi) && (s1_pyhi > s1_qylo);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mode   <= s1_mode;
      s2_rr     <= s2_rr_next;
      s2_dx     <= s2_dx_next;
      s2_dy     <= s2_dy_next;
      s2_lim    <= s1_lim;
      s2_lim_sq <= s1_lim * s1_lim;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Far-apart screen; past it both distances fit LIM_W bits, so squares stay narrow.
  logic [DW-1:0]   lim_e;
  logic            s3_far_next;
  mode_t           s3_mode;
  logic            s3_rr, s3_far;
  logic [SQ_W-1:0] s3_sqx, s3_sqy, s3_lim_sq;

  assign lim_e = {{(DW-LIM_W){1'b0}}, s2_lim};

  always_comb begin
    if (s2_mode == MODE_CC) s3_far_next = (s2_dx >= lim_e) || (s2_dy >= lim_e);
    else                    s3_far_next = (s2_dx > lim_e) || (s2_dy > lim_e);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mode   <= s2_mode;
      s3_rr     <= s2_rr;
      s3_far    <= s3_far_next;
      s3_sqx    <= s2_dx[LIM_W-1:0] * s2_dx[LIM_W-1:0];
      s3_sqy    <= s2_dy[LIM_W-1:0] * s2_dy[LIM_W-1:0];
      s3_lim_sq <= s2_lim_sq;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [SQ_W:0] dist_sq, lim_sq_e;
  logic          hit_next, hit;

  assign dist_sq  = {1'b0, s3_sqx} + {1'b0, s3_sqy};
  assign lim_sq_e = {1'b0, s3_lim_sq};

  always_comb begin
    unique case (s3_mode)
      MODE_RR: hit_next = s3_rr;
      MODE_RC: hit_next = !s3_far && (dist_sq <= lim_sq_e);
      MODE_CC: hit_next = !s3_far && (dist_sq < lim_sq_e);
      default: hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) hit <= hit_next;
  end

  assign m_tvalid = v4;
  assign m_tdata  = {7'd0, hit};

endmodule
